[src/vmnc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vmnc_pkg
// Shared widths, opcodes, pipeline record types and helpers for the vector
// magnitude normalize / clamp block.
// ----------------------------------------------------------------------------
package vmnc_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int COMP_W        = 32;
	localparam int MAG_W         = 31;
	localparam int ROOT_W        = 48;
	localparam int SQRT_STEPS    = 48;
	localparam int QUOT_W        = 33;
	localparam int DIV_STEPS     = 33;

	localparam logic [2:0] OP_NORM     = 3'd0;
	localparam logic [2:0] OP_CAP_MAX  = 3'd1;
	localparam logic [2:0] OP_CAP_MIN  = 3'd2;
	localparam logic [2:0] OP_CAP_BOTH = 3'd3;
	localparam logic [2:0] OP_CLAMP    = 3'd4;

	typedef struct packed {
		logic             zero;
		logic             en_a;
		logic             en_b;
		logic [MAG_W-1:0] tgt_a;
		logic [MAG_W-1:0] tgt_b;
		logic             sat;
	} vmnc_side_t;

	typedef struct packed {
		logic [2:0][COMP_W-1:0] vec;
		vmnc_side_t             side;
		logic [ROOT_W-1:0]      root;
	} vmnc_item_t;

	typedef struct packed {
		vmnc_item_t          item;
		logic [63:0]         s;
		logic [ROOT_W+1:0]   rem;
	} vmnc_sqrt_t;

	typedef struct packed {
		vmnc_item_t             item;
		logic                   act;
		logic [2:0]             neg;
		logic [2:0]             ovf;
		logic [2:0][ROOT_W-1:0] rem;
		logic [2:0][QUOT_W-1:0] low;
		logic [2:0][QUOT_W-1:0] q;
	} vmnc_div_t;

	typedef struct packed {
		logic [2:0][COMP_W-1:0] vec;
		logic                   sat;
		logic                   zero;
	} vmnc_res_t;

	function automatic logic [COMP_W-1:0] vmnc_abs(input logic [COMP_W-1:0] v);
		return v[COMP_W-1] ? (COMP_W'(0) - v) : v;
	endfunction

endpackage

[src/vmnc_sqrt_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vmnc_sqrt_cell
// One step of the digit-by-digit square root: brings in two radicand bits
// and settles one root bit.
// ----------------------------------------------------------------------------
module vmnc_sqrt_cell (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  vmnc_pkg::vmnc_sqrt_t in_data,
	output logic                 out_valid,
	output vmnc_pkg::vmnc_sqrt_t out_data
);

	logic [vmnc_pkg::ROOT_W+1:0] cur;
	logic [vmnc_pkg::ROOT_W+1:0] trial;
	logic                        take;
	vmnc_pkg::vmnc_sqrt_t        nxt;

	always_comb begin
		cur   = {in_data.rem[vmnc_pkg::ROOT_W-1:0], in_data.s[63:62]};
		trial = {in_data.item.root, 2'b01};
		take  = (cur >= trial);
		nxt   = in_data;
		// The radicand shifts up; below the top 64 bits the guard bits are zero.
		nxt.s = {in_data.s[61:0], 2'b00};
		nxt.rem = take ? (cur - trial) : cur;
		nxt.item.root = {in_data.item.root[vmnc_pkg::ROOT_W-2:0], take};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data <= nxt;
		end
	end

endmodule

[src/vmnc_div_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vmnc_div_cell
// One restoring division step for all three components against the root.
// ----------------------------------------------------------------------------
module vmnc_div_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  vmnc_pkg::vmnc_div_t in_data,
	output logic                out_valid,
	output vmnc_pkg::vmnc_div_t out_data
);

	logic [2:0][vmnc_pkg::ROOT_W:0] sh;
	logic [2:0][vmnc_pkg::ROOT_W:0] diff;
	logic [2:0]                     take;
	vmnc_pkg::vmnc_div_t            nxt;

	always_comb begin
		nxt = in_data;
		for (int c = 0; c < 3; c++) begin
			sh[c]   = {in_data.rem[c], in_data.low[c][vmnc_pkg::QUOT_W-1]};
			diff[c] = sh[c] - {1'b0, in_data.item.root};
			take[c] = (sh[c] >= {1'b0, in_data.item.root});
			nxt.rem[c] = take[c] ? diff[c][vmnc_pkg::ROOT_W-1:0]
			                     : sh[c][vmnc_pkg::ROOT_W-1:0];
			nxt.low[c] = {in_data.low[c][vmnc_pkg::QUOT_W-2:0], 1'b0};
			nxt.q[c]   = {in_data.q[c][vmnc_pkg::QUOT_W-2:0], take[c]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data <= nxt;
		end
	end

endmodule

[src/vmnc_scale.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vmnc_scale
// Rescales a vector by target / |v| with rounding and 32-bit saturation:
// multiply stage, setup stage, a row of divider cells and a finish stage.
// ----------------------------------------------------------------------------
module vmnc_scale (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  logic                           in_valid,
	input  vmnc_pkg::vmnc_item_t           in_item,
	input  logic                           act,
	input  logic [vmnc_pkg::MAG_W-1:0]     target,
	output logic                           out_valid,
	output vmnc_pkg::vmnc_item_t           out_item
);

	localparam int NUM_W = vmnc_pkg::COMP_W + vmnc_pkg::MAG_W;
	localparam int N_W   = NUM_W + 16;

	logic                   valid_s1;
	vmnc_pkg::vmnc_item_t   item_s1;
	logic                   act_s1;
	logic [2:0]             neg_s1;
	logic [2:0][NUM_W-1:0]  num_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s1 <= in_item;
			act_s1  <= act;
			for (int c = 0; c < 3; c++) begin
				neg_s1[c] <= in_item.vec[c][vmnc_pkg::COMP_W-1];
				num_s1[c] <= vmnc_pkg::vmnc_abs(in_item.vec[c]) * target;
			end
		end
	end

	// Round to nearest by adding half the divisor, then split off the high
	// part: a high part not below the root means the quotient overflows.
	logic [2:0][N_W-1:0]  n_wide;
	vmnc_pkg::vmnc_div_t  setup;

	always_comb begin
		setup      = '0;
		setup.item = item_s1;
		setup.act  = act_s1;
		setup.neg  = neg_s1;
		for (int c = 0; c < 3; c++) begin
			n_wide[c] = {num_s1[c], 16'd0} + N_W'(item_s1.root >> 1);
			setup.ovf[c] = ({2'b00, n_wide[c][N_W-1:vmnc_pkg::QUOT_W]} >= item_s1.root);
			setup.rem[c] = vmnc_pkg::ROOT_W'(n_wide[c][N_W-1:vmnc_pkg::QUOT_W]);
			setup.low[c] = n_wide[c][vmnc_pkg::QUOT_W-1:0];
		end
	end

	logic                 valid_s2;
	vmnc_pkg::vmnc_div_t  div_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			div_s2 <= setup;
		end
	end

	logic                [vmnc_pkg::DIV_STEPS:0] row_valid;
	vmnc_pkg::vmnc_div_t [vmnc_pkg::DIV_STEPS:0] row_data;

	assign row_valid[0] = valid_s2;
	assign row_data[0]  = div_s2;

	for (genvar k = 0; k < vmnc_pkg::DIV_STEPS; k++) begin : g_div
		vmnc_div_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.in_valid (row_valid[k]),
			.in_data  (row_data[k]),
			.out_valid(row_valid[k+1]),
			.out_data (row_data[k+1])
		);
	end

	vmnc_pkg::vmnc_div_t  fin;
	vmnc_pkg::vmnc_item_t res;
	logic [2:0]           sat_c;

	always_comb begin
		fin = row_data[vmnc_pkg::DIV_STEPS];
		res = fin.item;
		sat_c = 3'b000;
		if (fin.act) begin
			for (int c = 0; c < 3; c++) begin
				if (fin.neg[c]) begin
					if (fin.ovf[c] || fin.q[c] > 33'h0_8000_0000) begin
						res.vec[c] = 32'h8000_0000;
						sat_c[c]   = 1'b1;
					end else begin
						res.vec[c] = 32'd0 - fin.q[c][vmnc_pkg::COMP_W-1:0];
					end
				end else begin
					if (fin.ovf[c] || fin.q[c] > 33'h0_7FFF_FFFF) begin
						res.vec[c] = 32'h7FFF_FFFF;
						sat_c[c]   = 1'b1;
					end else begin
						res.vec[c] = fin.q[c][vmnc_pkg::COMP_W-1:0];
					end
				end
			end
		end
		res.side.sat = fin.item.side.sat | (|sat_c);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= row_valid[vmnc_pkg::DIV_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_item <= res;
		end
	end

endmodule

[src/vector_magnitude_normalize_clamp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector_magnitude_normalize_clamp
// Normalizes, magnitude-limits or clamps a 3D Q16.16 vector per request.
// ----------------------------------------------------------------------------
// From an accepted request to m_axis_tvalid: 3 front stages, 48 square-root
// cells and two scaling passes of 36 stages each.
// Throughput: one request per cycle; the pipeline advances whenever the
// two-entry output buffer has room.
// Reset clears all valid bits and empties the output buffer at once.
module vector_magnitude_normalize_clamp #(
	parameter int FRAC_BITS = vmnc_pkg::FRAC_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// vec_x[31:0], vec_y[63:32], vec_z[95:64], min_mag[126:96],
	// max_mag[157:127], zero fill[159:158]
	input  logic [159:0] s_axis_tdata,
	// opcode[2:0]
	input  logic [2:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// out_x[31:0], out_y[63:32], out_z[95:64]
	output logic [95:0]  m_axis_tdata,
	// zero_length[0], saturated[1]
	output logic [1:0]   m_axis_tuser
);

	localparam int CW = vmnc_pkg::COMP_W;
	localparam int MW = vmnc_pkg::MAG_W;

	logic [1:0] count_q;
	logic       en;

	assign en            = (count_q != 2'd2);
	assign s_axis_tready = en;

	// Front stage 1: squares of the components and of the limits.
	logic                  valid_s1;
	logic [2:0]            op_s1;
	logic [2:0][CW-1:0]    vec_s1;
	logic [2:0][63:0]      sq_s1;
	logic [MW-1:0]         mn_s1, mx_s1;
	logic [2*MW-1:0]       mn2_s1, mx2_s1;
	logic [2:0][CW-1:0]    vin;
	logic [2:0][CW-1:0]    ab;
	logic [MW-1:0]         mn_in, mx_in;

	assign vin   = s_axis_tdata[95:0];
	assign mn_in = s_axis_tdata[126:96];
	assign mx_in = s_axis_tdata[157:127];

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			ab[c] = vmnc_pkg::vmnc_abs(vin[c]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s1  <= s_axis_tuser;
			vec_s1 <= vin;
			mn_s1  <= mn_in;
			mx_s1  <= mx_in;
			mn2_s1 <= mn_in * mn_in;
			mx2_s1 <= mx_in * mx_in;
			for (int c = 0; c < 3; c++) begin
				sq_s1[c] <= ab[c] * ab[c];
			end
		end
	end

	// Front stage 2: sum of squares and the per-component clamp.
	logic                  valid_s2;
	logic [2:0]            op_s2;
	logic [2:0][CW-1:0]    vec_s2;
	logic [63:0]           sum_s2;
	logic [MW-1:0]         mn_s2, mx_s2;
	logic [2*MW-1:0]       mn2_s2, mx2_s2;
	logic [2:0][CW-1:0]    clamped;
	logic [CW-1:0]         pos_mx, neg_mx;

	always_comb begin
		pos_mx = {1'b0, mx_s1};
		neg_mx = CW'(0) - pos_mx;
		clamped = vec_s1;
		if (op_s1 == vmnc_pkg::OP_CLAMP) begin
			for (int c = 0; c < 3; c++) begin
				if ($signed(vec_s1[c]) > $signed(pos_mx)) begin
					clamped[c] = pos_mx;
				end else if ($signed(vec_s1[c]) < $signed(neg_mx)) begin
					clamped[c] = neg_mx;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s2  <= op_s1;
			vec_s2 <= clamped;
			sum_s2 <= sq_s1[0] + sq_s1[1] + sq_s1[2];
			mn_s2  <= mn_s1;
			mx_s2  <= mx_s1;
			mn2_s2 <= mn2_s1;
			mx2_s2 <= mx2_s1;
		end
	end

	// Front stage 3: decide which scaling passes run and with which target.
	logic                 valid_s3;
	vmnc_pkg::vmnc_sqrt_t sq_init;
	vmnc_pkg::vmnc_sqrt_t sqin_s3;
	logic                 is_scale_op;
	logic                 below_min, above_max;

	always_comb begin
		is_scale_op = (op_s2 == vmnc_pkg::OP_NORM) || (op_s2 == vmnc_pkg::OP_CAP_MAX) ||
		              (op_s2 == vmnc_pkg::OP_CAP_MIN) || (op_s2 == vmnc_pkg::OP_CAP_BOTH);
		below_min = (sum_s2 < {2'b00, mn2_s2});
		above_max = (sum_s2 > {2'b00, mx2_s2});
		sq_init = '0;
		sq_init.s = sum_s2;
		sq_init.item.vec = vec_s2;
		sq_init.item.side.tgt_b = mx_s2;
		sq_init.item.side.zero = is_scale_op && (sum_s2 == 64'd0);
		if (is_scale_op && (sum_s2 != 64'd0)) begin
			case (op_s2)
				vmnc_pkg::OP_NORM: begin
					sq_init.item.side.en_a  = 1'b1;
					sq_init.item.side.tgt_a = MW'(1) << FRAC_BITS;
				end
				vmnc_pkg::OP_CAP_MAX: begin
					sq_init.item.side.en_a  = above_max;
					sq_init.item.side.tgt_a = mx_s2;
				end
				vmnc_pkg::OP_CAP_MIN: begin
					sq_init.item.side.en_a  = below_min;
					sq_init.item.side.tgt_a = mn_s2;
				end
				vmnc_pkg::OP_CAP_BOTH: begin
					sq_init.item.side.en_a  = below_min;
					sq_init.item.side.tgt_a = mn_s2;
					sq_init.item.side.en_b  = above_max;
				end
				default: begin
					sq_init.item.side.en_a = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sqin_s3 <= sq_init;
		end
	end

	// Square-root row: the root of sum * 2^32, one bit per cell.
	logic                 [vmnc_pkg::SQRT_STEPS:0] sq_valid;
	vmnc_pkg::vmnc_sqrt_t [vmnc_pkg::SQRT_STEPS:0] sq_data;

	assign sq_valid[0] = valid_s3;
	assign sq_data[0]  = sqin_s3;

	for (genvar k = 0; k < vmnc_pkg::SQRT_STEPS; k++) begin : g_sqrt
		vmnc_sqrt_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.in_valid (sq_valid[k]),
			.in_data  (sq_data[k]),
			.out_valid(sq_valid[k+1]),
			.out_data (sq_data[k+1])
		);
	end

	vmnc_pkg::vmnc_item_t root_item;
	assign root_item = sq_data[vmnc_pkg::SQRT_STEPS].item;

	logic                 a_valid, b_valid;
	vmnc_pkg::vmnc_item_t a_item, b_item;

	vmnc_scale u_scale_a (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (sq_valid[vmnc_pkg::SQRT_STEPS]),
		.in_item  (root_item),
		.act      (root_item.side.en_a),
		.target   (root_item.side.tgt_a),
		.out_valid(a_valid),
		.out_item (a_item)
	);

	// The second pass works on the saturated result of the first, with the
	// magnitude of the original vector.
	vmnc_scale u_scale_b (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (a_valid),
		.in_item  (a_item),
		.act      (a_item.side.en_b),
		.target   (a_item.side.tgt_b),
		.out_valid(b_valid),
		.out_item (b_item)
	);

	// Two-entry output buffer.
	vmnc_pkg::vmnc_res_t buf_q [2];
	logic                wr_ptr_q, rd_ptr_q;
	logic                push, pop;
	vmnc_pkg::vmnc_res_t res_in;

	assign push = en && b_valid;
	assign pop  = m_axis_tvalid && m_axis_tready;

	always_comb begin
		res_in.vec  = b_item.vec;
		res_in.sat  = b_item.side.sat;
		res_in.zero = b_item.side.zero;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= 2'd0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= res_in;
		end
	end

	assign m_axis_tvalid = (count_q != 2'd0);
	assign m_axis_tdata  = buf_q[rd_ptr_q].vec;
	assign m_axis_tuser  = {buf_q[rd_ptr_q].sat, buf_q[rd_ptr_q].zero};

endmodule

[src/vmnc_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vmnc_checker
// Port-level checks for the vector magnitude block, bound to the top level.
// ----------------------------------------------------------------------------
module vmnc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [95:0] m_axis_tdata,
	input logic [1:0]  m_axis_tuser
);

	// A stalled result stays offered.
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result request dropped while stalled");

	// A stalled result keeps its payload.
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result payload changed while stalled");

	// A zero-length vector is never rescaled, so it cannot be saturated.
	a_zero_not_sat: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> !m_axis_tuser[1])
		else $error("zero-length result flagged as saturated");

	// Input backpressure only comes from a full output buffer.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid)
		else $error("input stalled with no result waiting");

endmodule

bind vector_magnitude_normalize_clamp vmnc_checker u_vmnc_checker (.*);
